// ----- rtl/detector_baseline_tone_control_defines.svh -----
// Assertion macros shared by the detector tone control modules.
`ifndef DETECTOR_BASELINE_TONE_CONTROL_DEFINES_SVH
`define DETECTOR_BASELINE_TONE_CONTROL_DEFINES_SVH

// Checks a consequence in the same cycle as its condition.
`define DBTC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks a consequence in the cycle after its condition.
`define DBTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dbtc_pkg.sv -----
// Shared constants, types and command/status structs of the detector tone control.
package dbtc_pkg;

   localparam int WINDOW = 16;
   localparam int WARMUP = 16;
   localparam int LIMIT  = WARMUP * WINDOW;

   localparam int SMP_W  = 16;
   localparam int SUM_W  = SMP_W + $clog2(WINDOW);
   localparam int CNT_W  = $clog2(LIMIT + 1);
   localparam int FREQ_W = 11;
   localparam int PER_W  = 10;
   localparam int DUTY_W = 20;
   localparam int NUM_W  = 20;

   localparam logic [CNT_W-1:0]  SAMPLE_LIMIT = CNT_W'(LIMIT);
   localparam logic [NUM_W-1:0]  TICK_DIVIDEND = NUM_W'(1000000);
   localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(2000);
   localparam logic [FREQ_W-1:0] FREQ_MIN = FREQ_W'(1000);
   localparam logic [SMP_W-1:0]  DIST_MAX = SMP_W'(20);
   localparam logic [PER_W-1:0]  PERIOD_MIN = PER_W'(500);
   localparam logic [PER_W-1:0]  PERIOD_MAX = PER_W'(1000);
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   // Period divided by 100 is taken as (period * 1311) >> 17, exact for periods up to 1000.
   localparam int RECIP_W = 11;
   localparam logic [RECIP_W-1:0] PERIOD_RECIP = RECIP_W'(1311);
   localparam int RECIP_SHIFT = 17;
   localparam int PROD_W = PER_W + RECIP_W;
   localparam int SCALE_W = PROD_W - RECIP_SHIFT;

   localparam logic [1:0] REQ_PROCESS = 2'd0;
   localparam logic [1:0] REQ_COMPARE = 2'd1;
   localparam logic [1:0] REQ_UPDATE  = 2'd2;

   localparam logic [1:0] CSR_SENSITIVITY = 2'd0;
   localparam logic [1:0] CSR_VOLUME      = 2'd1;
   localparam logic [1:0] CSR_PIN_POINT   = 2'd2;

   typedef struct packed {
      logic capture;
      logic apply;
      logic average;
      logic decide;
      logic scale;
      logic duty;
      logic load;
   } dbtc_cmd_type;

   typedef struct packed {
      logic tone_path;
      logic fire;
      logic div_done;
      logic out_free;
   } dbtc_status_type;

endpackage

// ----- rtl/dbtc_divider.sv -----
// Restoring divider that computes the tone period from the tone frequency, one bit a cycle.
`include "detector_baseline_tone_control_defines.svh"
module dbtc_divider
   import dbtc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FREQ_W-1:0] divisor,
   output logic              done,
   output logic [PER_W-1:0]  quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [FREQ_W-1:0] divisor_ff, divisor_in;
   logic [FREQ_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [PER_W-1:0]  quo_ff, quo_in;
   logic [FREQ_W:0]   trial;
   logic [FREQ_W:0]   diff;
   logic              take;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign take  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         divisor_in = divisor;
         rem_in     = '0;
         num_in     = TICK_DIVIDEND;
         quo_in     = '0;
      end else if (busy_ff) begin
         rem_in = take ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         // The quotient never exceeds ten bits, so the upper bits shifted out are zero.
         quo_in = {quo_ff[PER_W-2:0], take};
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `DBTC_ASSERT_NEXT(a_start_busy, start, busy_ff, "divider did not start")
   `DBTC_ASSERT_SAME(a_quotient_range, done_ff, quo_ff >= PERIOD_MIN && quo_ff <= PERIOD_MAX,
                     "tone period out of range")

endmodule

// ----- rtl/dbtc_datapath.sv -----
// Datapath: sample windows, running sums, hysteresis decision, period and duty, result register.
`include "detector_baseline_tone_control_defines.svh"
module dbtc_datapath
   import dbtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dbtc_cmd_type          cmd,
   output dbtc_status_type       status,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [SMP_W-1:0]      csr_wdata,
   input  logic [1:0]            req_type,
   input  logic [SMP_W-1:0]      req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SMP_W-1:0]      rsp_search_value,
   output logic [DUTY_W-1:0]     rsp_tone_duty,
   output logic [PER_W-1:0]      rsp_tone_period,
   output logic                  rsp_start_burst,
   output logic                  rsp_warming_up
);

   logic [SMP_W-1:0]  sens_ff, volume_ff;
   logic              pin_ff;

   logic [1:0]        type_ff;
   logic [SMP_W-1:0]  sample_ff;
   logic              warm_ff;

   logic [SMP_W-1:0]  base_win_ff   [WINDOW];
   logic [SMP_W-1:0]  base_win_in   [WINDOW];
   logic [SMP_W-1:0]  search_win_ff [WINDOW];
   logic [SMP_W-1:0]  search_win_in [WINDOW];
   logic [SUM_W-1:0]  base_sum_ff, base_sum_in;
   logic [SUM_W-1:0]  search_sum_ff, search_sum_in;
   logic [SMP_W-1:0]  ref_ff, ref_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SMP_W-1:0]  search_avg_ff, search_avg_in;
   logic [SMP_W-1:0]  last_diff_ff, last_diff_in;
   logic              burst_ff, burst_in;
   logic              pending_ff, pending_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [PER_W-1:0]  period_ff, period_in;
   logic [SMP_W-1:0]  dist_ff, dist_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              started_ff, started_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SMP_W-1:0]  rsp_value_ff;
   logic [DUTY_W-1:0] rsp_duty_ff;
   logic [PER_W-1:0]  rsp_period_ff;
   logic              rsp_start_ff;
   logic              rsp_warm_ff;

   logic              sample_nz;
   logic [SMP_W-1:0]  base_avg;
   logic [SMP_W-1:0]  avg_diff;
   logic              fire;
   logic              hold;
   logic              div_done;
   logic [PER_W-1:0]  quotient;
   logic [SUM_W-1:0]  search_sum_next;

   assign sample_nz = sample_ff != '0;
   assign base_avg  = SMP_W'(base_sum_ff / SUM_W'(WINDOW));
   assign avg_diff  = (base_avg >= search_avg_ff) ? base_avg - search_avg_ff
                                                  : search_avg_ff - base_avg;
   assign fire      = (avg_diff > sens_ff) && !burst_ff;
   // Inside the hysteresis band a pending burst compare keeps the current tone.
   assign hold      = pending_ff &&
                      !(({1'b0, avg_diff} + (SMP_W+1)'(2)) < {1'b0, sens_ff});

   assign search_sum_next = search_sum_ff + SUM_W'(sample_ff)
                            - SUM_W'(search_win_ff[WINDOW-1]);

   dbtc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.decide && fire),
      .divisor  (freq_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff   <= '0;
         volume_ff <= '0;
         pin_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SENSITIVITY: sens_ff   <= csr_wdata;
            CSR_VOLUME:      volume_ff <= csr_wdata;
            CSR_PIN_POINT:   pin_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      base_win_in   = base_win_ff;
      search_win_in = search_win_ff;
      base_sum_in   = base_sum_ff;
      search_sum_in = search_sum_ff;
      ref_in        = ref_ff;
      count_in      = count_ff;
      search_avg_in = search_avg_ff;
      last_diff_in  = last_diff_ff;
      burst_in      = burst_ff;
      pending_in    = pending_ff;
      duty_in       = duty_ff;
      period_in     = period_ff;
      dist_in       = dist_ff;
      freq_in       = freq_ff;
      prod_in       = prod_ff;
      started_in    = started_ff;

      if (cmd.capture) begin
         started_in = 1'b0;
      end

      if (cmd.apply) begin
         case (type_ff)
            REQ_COMPARE: begin
               pending_in = 1'b0;
            end
            REQ_UPDATE: begin
               burst_in    = 1'b0;
               base_win_in = search_win_ff;
               base_sum_in = search_sum_ff;
            end
            REQ_PROCESS: begin
               dist_in = '0;
               if (warm_ff) begin
                  duty_in = '0;
                  if (sample_nz) begin
                     base_win_in[0]   = sample_ff;
                     search_win_in[0] = sample_ff;
                     for (int i = 1; i < WINDOW; i++) begin
                        base_win_in[i]   = base_win_ff[i-1];
                        search_win_in[i] = search_win_ff[i-1];
                     end
                     base_sum_in   = base_sum_ff + SUM_W'(sample_ff)
                                     - SUM_W'(base_win_ff[WINDOW-1]);
                     search_sum_in = search_sum_next;
                     ref_in        = sample_ff;
                     count_in      = count_ff + CNT_W'(1);
                     pending_in    = 1'b0;
                     burst_in      = 1'b0;
                  end
               end else if (sample_nz) begin
                  search_win_in[0] = sample_ff;
                  for (int i = 1; i < WINDOW; i++) begin
                     search_win_in[i] = search_win_ff[i-1];
                  end
                  search_sum_in = search_sum_next;
                  dist_in = (ref_ff > sample_ff) ? ref_ff - sample_ff : sample_ff - ref_ff;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.average) begin
         if (sample_nz) begin
            search_avg_in = SMP_W'(search_sum_ff / SUM_W'(WINDOW));
         end
         // An offset of 50 per count reaches the 1000 floor beyond a distance of 20.
         if (dist_ff <= DIST_MAX) begin
            freq_in = FREQ_MAX - ((FREQ_W'(dist_ff) << 5) + (FREQ_W'(dist_ff) << 4)
                                  + (FREQ_W'(dist_ff) << 1));
         end else begin
            freq_in = FREQ_MIN;
         end
      end

      if (cmd.decide) begin
         last_diff_in = avg_diff;
         if (fire) begin
            if (!pin_ff) begin
               pending_in = 1'b1;
               burst_in   = 1'b1;
               started_in = 1'b1;
            end
         end else if (!hold) begin
            duty_in = '0;
         end
      end

      if (cmd.scale) begin
         period_in = quotient;
         prod_in   = PROD_W'(quotient) * PROD_W'(PERIOD_RECIP);
      end

      if (cmd.duty) begin
         duty_in = DUTY_W'(prod_ff[PROD_W-1:RECIP_SHIFT]) * DUTY_W'(volume_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            base_win_ff[i]   <= '0;
            search_win_ff[i] <= '0;
         end
         base_sum_ff   <= '0;
         search_sum_ff <= '0;
         ref_ff        <= '0;
         count_ff      <= '0;
         search_avg_ff <= '0;
         last_diff_ff  <= '0;
         burst_ff      <= 1'b0;
         pending_ff    <= 1'b0;
         duty_ff       <= '0;
         period_ff     <= '0;
      end else begin
         base_win_ff   <= base_win_in;
         search_win_ff <= search_win_in;
         base_sum_ff   <= base_sum_in;
         search_sum_ff <= search_sum_in;
         ref_ff        <= ref_in;
         count_ff      <= count_in;
         search_avg_ff <= search_avg_in;
         last_diff_ff  <= last_diff_in;
         burst_ff      <= burst_in;
         pending_ff    <= pending_in;
         duty_ff       <= duty_in;
         period_ff     <= period_in;
      end
      dist_ff    <= dist_in;
      freq_ff    <= freq_in;
      prod_ff    <= prod_in;
      started_ff <= started_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff   <= req_type;
         sample_ff <= req_sample;
         warm_ff   <= count_ff < SAMPLE_LIMIT;
      end
   end

   // Result register: the next transaction may run while this one waits to be taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load) begin
         rsp_value_ff  <= last_diff_ff;
         rsp_duty_ff   <= duty_ff;
         rsp_period_ff <= period_ff;
         rsp_start_ff  <= started_ff;
         rsp_warm_ff   <= warm_ff;
      end
   end

   assign status.tone_path = (type_ff == REQ_PROCESS) && !warm_ff;
   assign status.fire      = fire;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_search_value = rsp_value_ff;
   assign rsp_tone_duty    = rsp_duty_ff;
   assign rsp_tone_period  = rsp_period_ff;
   assign rsp_start_burst  = rsp_start_ff;
   assign rsp_warming_up   = rsp_warm_ff;

   `DBTC_ASSERT_SAME(a_count_saturates, 1'b1, count_ff <= SAMPLE_LIMIT,
                     "sample count passed the warm-up limit")
   `DBTC_ASSERT_SAME(a_start_sets_lockout, cmd.load && started_ff, burst_ff && pending_ff,
                     "burst started without lockout flags")

endmodule

// ----- rtl/dbtc_ctrl.sv -----
// Controller state machine that sequences one transaction through the datapath.
`include "detector_baseline_tone_control_defines.svh"
module dbtc_ctrl
   import dbtc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dbtc_status_type status,
   output dbtc_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_APPLY   = 8'b0000_0010,
      ST_AVERAGE = 8'b0000_0100,
      ST_DECIDE  = 8'b0000_1000,
      ST_DIVIDE  = 8'b0001_0000,
      ST_SCALE   = 8'b0010_0000,
      ST_DUTY    = 8'b0100_0000,
      ST_RESULT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = status.tone_path ? ST_AVERAGE : ST_RESULT;
         end
         ST_AVERAGE: begin
            cmd.average = 1'b1;
            state_in    = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.fire ? ST_DIVIDE : ST_RESULT;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DUTY;
         end
         ST_DUTY: begin
            cmd.duty = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   `DBTC_ASSERT_NEXT(a_fire_divides, state_ff == ST_DECIDE && status.fire,
                     state_ff == ST_DIVIDE, "tone decision did not start the divider")

endmodule

// ----- rtl/detector_baseline_tone_control.sv -----
// Top level of the detector baseline and search-window tone control.
// One transaction at a time is processed. An event transaction, an unused request type or a
// warm-up sample goes from APPLY to RESULT; a sample after warm-up that leaves the tone
// alone also passes AVERAGE and DECIDE; one that sounds a new tone also waits in DIVIDE for
// the 20-step bit-serial divider that turns the tone frequency into its period, then passes
// SCALE and DUTY. The result sits in an output register, so a new transaction is accepted
// while a finished one waits to be taken. Configuration registers: index 0 sensitivity,
// 1 volume, 2 pin-point mode; write them only while no transaction is in flight.
module detector_baseline_tone_control
   import dbtc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [SMP_W-1:0]  csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [SMP_W-1:0]  req_sample,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SMP_W-1:0]  rsp_search_value,
   output logic [DUTY_W-1:0] rsp_tone_duty,
   output logic [PER_W-1:0]  rsp_tone_period,
   output logic              rsp_start_burst,
   output logic              rsp_warming_up
);

   dbtc_cmd_type    cmd;
   dbtc_status_type status;

   dbtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dbtc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_type         (req_type),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_search_value (rsp_search_value),
      .rsp_tone_duty    (rsp_tone_duty),
      .rsp_tone_period  (rsp_tone_period),
      .rsp_start_burst  (rsp_start_burst),
      .rsp_warming_up   (rsp_warming_up)
   );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the detector baseline and search-window tone control.
module testbench
   import dbtc_pkg::*;
;

   // The request type that the block ignores.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_ITEMS = 140;
   localparam int NUM_PHASES = 8;

   typedef struct packed {
      logic [SMP_W-1:0]  search_value;
      logic [DUTY_W-1:0] duty;
      logic [PER_W-1:0]  period;
      logic              start_burst;
      logic              warming_up;
   } tone_result_type;

   class tone_scoreboard;
      logic [SMP_W-1:0] baseline_win[WINDOW];
      logic [SMP_W-1:0] search_win[WINDOW];
      logic [SMP_W-1:0] ref_smp;
      logic [SMP_W-1:0] search_avg;
      logic [SMP_W-1:0] last_diff;
      int unsigned smp_count;
      bit burst_active;
      bit compare_pending;
      logic [DUTY_W-1:0] duty;
      logic [PER_W-1:0] period;
      logic [SMP_W-1:0] sens;
      logic [SMP_W-1:0] vol;
      bit pin_point;
      tone_result_type expected_q[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned bursts;
      int unsigned lockouts;

      function new();
         foreach (baseline_win[i]) begin
            baseline_win[i] = '0;
            search_win[i] = '0;
         end
         ref_smp = '0;
         search_avg = '0;
         last_diff = '0;
         smp_count = 0;
         burst_active = 0;
         compare_pending = 0;
         duty = '0;
         period = '0;
         sens = '0;
         vol = '0;
         pin_point = 0;
         errors = 0;
         checked = 0;
         bursts = 0;
         lockouts = 0;
      endfunction

      function void set_config(logic [SMP_W-1:0] s, logic [SMP_W-1:0] v, bit p);
         sens = s;
         vol = v;
         pin_point = p;
      endfunction

      function bit warm();
         return smp_count < LIMIT;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function logic [SMP_W-1:0] mean_of(logic [SMP_W-1:0] w[WINDOW]);
         int unsigned sum;
         sum = 0;
         foreach (w[i]) sum += w[i];
         return SMP_W'(sum / WINDOW);
      endfunction

      // Advances the block's state by one accepted transaction and queues its result.
      function void note_request(logic [1:0] kind, logic [SMP_W-1:0] smp);
         bit was_warm;
         bit started;
         int unsigned offset;
         int unsigned d;
         int unsigned freq;
         int unsigned period_full;
         int diff;
         logic [SMP_W-1:0] base_avg;
         tone_result_type r;
         was_warm = warm();
         started = 0;
         case (kind)
            REQ_COMPARE: begin
               compare_pending = 0;
            end
            REQ_UPDATE: begin
               burst_active = 0;
               baseline_win = search_win;
            end
            REQ_PROCESS: begin
               if (was_warm) begin
                  duty = '0;
                  if (smp != 0) begin
                     for (int i = WINDOW - 1; i > 0; i--) begin
                        baseline_win[i] = baseline_win[i-1];
                        search_win[i] = search_win[i-1];
                     end
                     baseline_win[0] = smp;
                     search_win[0] = smp;
                     ref_smp = smp;
                     smp_count++;
                     compare_pending = 0;
                     burst_active = 0;
                  end
               end else begin
                  offset = 0;
                  if (smp != 0) begin
                     for (int i = WINDOW - 1; i > 0; i--) search_win[i] = search_win[i-1];
                     search_win[0] = smp;
                     search_avg = mean_of(search_win);
                     d = (ref_smp > smp) ? int'(ref_smp) - int'(smp)
                                         : int'(smp) - int'(ref_smp);
                     offset = d * 50;
                  end
                  base_avg = mean_of(baseline_win);
                  diff = int'(base_avg) - int'(search_avg);
                  if (diff < 0) diff = -diff;
                  last_diff = SMP_W'(diff);
                  if (diff > int'(sens) && !burst_active) begin
                     if (offset < 2000) begin
                        freq = 2000 - offset;
                        if (freq < 1000) freq = 1000;
                     end else begin
                        freq = 1000;
                     end
                     period_full = 1000000 / freq;
                     period = PER_W'(period_full);
                     duty = DUTY_W'((period_full / 100) * vol);
                     if (!pin_point) begin
                        compare_pending = 1;
                        burst_active = 1;
                        started = 1;
                        bursts++;
                     end
                  end else if (diff < int'(sens) - 2) begin
                     if (diff > int'(sens)) lockouts++;
                     duty = '0;
                  end else if (!compare_pending) begin
                     if (diff > int'(sens)) lockouts++;
                     duty = '0;
                  end else if (diff > int'(sens)) begin
                     lockouts++;
                  end
               end
            end
            default: begin
            end
         endcase
         r.search_value = last_diff;
         r.duty = duty;
         r.period = period;
         r.start_burst = started;
         r.warming_up = was_warm;
         expected_q.push_back(r);
      endfunction

      function void check_result(tone_result_type got);
         tone_result_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: search_value %0d tone_duty %0d tone_period %0d",
                   got.search_value, got.duty, got.period);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.search_value !== want.search_value) begin
            $error("search_value: expected %0d, actual %0d", want.search_value,
                   got.search_value);
            errors++;
         end
         if (got.duty !== want.duty) begin
            $error("tone_duty: expected %0d, actual %0d", want.duty, got.duty);
            errors++;
         end
         if (got.period !== want.period) begin
            $error("tone_period: expected %0d, actual %0d", want.period, got.period);
            errors++;
         end
         if (got.start_burst !== want.start_burst) begin
            $error("start_burst: expected %0d, actual %0d", want.start_burst,
                   got.start_burst);
            errors++;
         end
         if (got.warming_up !== want.warming_up) begin
            $error("warming_up: expected %0d, actual %0d", want.warming_up,
                   got.warming_up);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [SMP_W-1:0]  csr_wdata;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_type;
   logic [SMP_W-1:0]  req_sample;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [SMP_W-1:0]  rsp_search_value;
   logic [DUTY_W-1:0] rsp_tone_duty;
   logic [PER_W-1:0]  rsp_tone_period;
   logic              rsp_start_burst;
   logic              rsp_warming_up;

   tone_scoreboard sb;
   bit calm;
   int unsigned sent_count;
   int unsigned idle_cycles;

   detector_baseline_tone_control dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_search_value (rsp_search_value),
      .rsp_tone_duty    (rsp_tone_duty),
      .rsp_tone_period  (rsp_tone_period),
      .rsp_start_burst  (rsp_start_burst),
      .rsp_warming_up   (rsp_warming_up)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The result side stalls for a random number of cycles before taking each transaction.
   initial begin : result_sink
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 5);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (reset || !rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_search_value, rsp_tone_duty, rsp_tone_period,
                          rsp_start_burst, rsp_warming_up});
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", sb.pending());
         $display("detector_baseline_tone_control regression: fail");
         $finish;
      end
   end

   task automatic write_config(logic [SMP_W-1:0] s, logic [SMP_W-1:0] v, bit p);
      csr_we <= 1'b1;
      csr_index <= CSR_SENSITIVITY;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_VOLUME;
      csr_wdata <= v;
      @(posedge clock);
      csr_index <= CSR_PIN_POINT;
      csr_wdata <= {{(SMP_W-1){1'b0}}, p};
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_config(s, v, p);
   endtask

   task automatic send(logic [1:0] kind, logic [SMP_W-1:0] smp);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_sample <= smp;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, smp);
      sent_count++;
   endtask

   // Holds the request side off until every queued result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   function automatic logic [SMP_W-1:0] near(logic [SMP_W-1:0] center, int span);
      int v;
      v = int'(center) + int'($urandom_range(0, 2 * span)) - span;
      if (v < 1) v = 1;
      if (v > 65535) v = 65535;
      return SMP_W'(v);
   endfunction

   task automatic random_item();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8)
         send(REQ_COMPARE, SMP_W'($urandom_range(0, 65535)));
      else if (r < 18)
         send(REQ_UPDATE, SMP_W'($urandom_range(0, 65535)));
      else if (r < 20)
         send(REQ_UNUSED, SMP_W'($urandom_range(0, 65535)));
      else if (r < 26)
         send(REQ_PROCESS, '0);
      else if (r < 72)
         send(REQ_PROCESS, near(sb.ref_smp, 45));
      else if (r < 88)
         send(REQ_PROCESS, near(sb.search_avg, 8));
      else
         send(REQ_PROCESS, SMP_W'($urandom_range(1, 65535)));
   endtask

   initial begin : stimulus
      logic [SMP_W-1:0] sens_set[NUM_PHASES];
      logic [SMP_W-1:0] vol_set[NUM_PHASES];
      bit pin_set[NUM_PHASES];
      logic [SMP_W-1:0] center;
      int unsigned r;
      sb = new();
      calm = 0;
      sent_count = 0;
      idle_cycles = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SENSITIVITY;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_type = REQ_PROCESS;
      req_sample = '0;
      sens_set = '{16'd0, 16'd1, 16'd2, 16'd65535, 16'd5,
                   SMP_W'($urandom_range(3, 40)), SMP_W'($urandom_range(0, 65535)), 16'd3};
      vol_set = '{16'd65535, 16'd100, 16'd0, 16'd65535, SMP_W'($urandom_range(0, 65535)),
                  16'd65535, SMP_W'($urandom_range(0, 65535)), 16'd1};
      pin_set = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_config(16'd0, 16'd65535, 1'b0);

      // Events, the unused type and edge samples while the windows are still filling.
      send(REQ_COMPARE, '0);
      send(REQ_UPDATE, 16'hFFFF);
      send(REQ_UNUSED, 16'hFFFF);
      send(REQ_PROCESS, '0);
      send(REQ_PROCESS, 16'hFFFF);
      send(REQ_PROCESS, 16'h0001);
      send(REQ_PROCESS, 16'hAAAA);
      send(REQ_PROCESS, 16'h5555);

      // Finish warm-up around one level so that later samples land near the reference.
      center = SMP_W'($urandom_range(100, 65000));
      while (sb.warm()) begin
         r = $urandom_range(0, 99);
         if (r < 5)
            send(REQ_COMPARE, SMP_W'($urandom_range(0, 65535)));
         else if (r < 9)
            send(REQ_UPDATE, SMP_W'($urandom_range(0, 65535)));
         else if (r < 11)
            send(REQ_UNUSED, SMP_W'($urandom_range(0, 65535)));
         else if (r < 14)
            send(REQ_PROCESS, '0);
         else if (r < 22)
            send(REQ_PROCESS, SMP_W'($urandom_range(1, 65535)));
         else
            send(REQ_PROCESS, near(center, 30));
      end

      // After warm-up: an empty call, a far sample, lockout, both events, the unused type.
      send(REQ_PROCESS, '0);
      send(REQ_PROCESS, 16'hFFFF);
      send(REQ_PROCESS, sb.ref_smp);
      send(REQ_PROCESS, 16'h0001);
      send(REQ_COMPARE, '0);
      send(REQ_PROCESS, sb.ref_smp);
      send(REQ_UPDATE, '0);
      send(REQ_PROCESS, near(sb.ref_smp, 25));
      send(REQ_UNUSED, 16'h5A5A);
      send(REQ_PROCESS, near(sb.ref_smp, 2));

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_config(sens_set[p], vol_set[p], pin_set[p]);
         calm = (p % 3 == 1);
         repeat (PHASE_ITEMS) random_item();
      end
      drain();

      $display("Sent %0d transactions through warm-up and %0d register settings; %0d checked.",
               sent_count, NUM_PHASES + 1, sb.checked);
      $display("Tone bursts started: %0d; calls held off by an active burst: %0d.",
               sb.bursts, sb.lockouts);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("detector_baseline_tone_control regression: pass");
      end else begin
         $display("detector_baseline_tone_control regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dbtc_pkg.sv
rtl/dbtc_divider.sv
rtl/dbtc_datapath.sv
rtl/dbtc_ctrl.sv
rtl/detector_baseline_tone_control.sv
tb/testbench.sv
